### rtl/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg - shared definitions for the signed integer to decimal text block
// Character codes, the conversion step size and the character request type.
// ----------------------------------------------------------------------------
package sida_pkg;

  // default width of the integer input
  localparam int VALUE_WIDTH_DEF = 32;

  // magnitude bits folded into the BCD register per cycle
  localparam int BITS_PER_STEP = 2;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // one character request towards the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] character;
    logic       last_char;
  } char_req_t;

endpackage

### rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii - signed integer to decimal ASCII text
// Sequenced binary to BCD conversion with a character output register.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream s_axis_*: one request carries a signed integer in the low
//    VALUE_WIDTH bits of tdata. tready is high only while the block is idle.
//  - Output stream m_axis_*: one request per character, most significant
//    first, a leading '-' for negative values, tlast on the final digit.
//    Zero gives the single character '0'; the most negative value converts
//    exactly through its unsigned magnitude.
//  - Timing: the magnitude is folded into BCD two bits a cycle through one
//    shared add-3/shift unit until all magnitude bits are in. Leading zero
//    digits are then dropped one per cycle, then one decision is made and
//    the characters are emitted. An integer passes through the accept, the
//    conversion, the zero drop, the decision, the sign when negative and
//    one emit step per remaining digit; each emit holds while the receiver
//    stalls.
//  - The final character sits in the output register, so the next integer
//    is accepted while it still waits for the receiver.
//  - Stall: a low m_axis_tready holds the current character and halts the
//    sequencer when it next offers a character; nothing is lost or repeated.
//  - Reset (rst_ni low, asynchronous) empties the output register and
//    returns the sequencer to idle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii import sida_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // [W-1:0] value
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,  // [7:0] character
  output logic                                m_axis_tlast   // last_char
);

  localparam int Digits = VALUE_WIDTH * 3 / 10 + 1;
  localparam int BcdW   = 4 * Digits;
  localparam int Steps  = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int MagW   = Steps * BITS_PER_STEP;
  localparam int StepW  = $clog2(Steps + 1);
  localparam int LeftW  = $clog2(Digits + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SKIP = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [MagW-1:0]  mag_q, mag_d;
  logic [BcdW-1:0]  bcd_q, bcd_d;
  logic             neg_q, neg_d;
  logic [StepW-1:0] step_q, step_d;
  logic [LeftW-1:0] left_q, left_d;

  logic [VALUE_WIDTH-1:0] value;
  logic [VALUE_WIDTH-1:0] mag_abs;
  logic [BcdW-1:0]        bcd_step;
  logic [3:0]             top_digit;
  logic [BcdW-1:0]        bcd_shl;
  char_req_t              out_req;
  logic                   out_ready;

  assign value   = s_axis_tdata[VALUE_WIDTH-1:0];
  // two's complement negation; the most negative value maps onto itself,
  // which read unsigned is its exact magnitude
  assign mag_abs = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;

  assign s_axis_tready = (state_q == S_IDLE);

  assign top_digit = bcd_q[BcdW-1 -: 4];
  assign bcd_shl   = {bcd_q[BcdW-5:0], 4'b0000};

  sida_dabble_step #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_step (
    .bcd_i  (bcd_q),
    .bits_i (mag_q[MagW-1 -: BITS_PER_STEP]),
    .bcd_o  (bcd_step)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    step_d  = step_q;
    left_d  = left_q;
    out_req = '{valid: 1'b0, character: ASCII_ZERO, last_char: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          neg_d   = value[VALUE_WIDTH-1];
          mag_d   = MagW'(mag_abs);
          bcd_d   = '0;
          step_d  = '0;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        bcd_d  = bcd_step;
        mag_d  = {mag_q[MagW-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(Steps - 1)) begin
          left_d  = LeftW'(Digits);
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, always keep the units digit
        if (top_digit == 4'd0 && left_q > LeftW'(1)) begin
          bcd_d  = bcd_shl;
          left_d = left_q - LeftW'(1);
        end else if (neg_q) begin
          state_d = S_SIGN;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_SIGN: begin
        out_req = '{valid: 1'b1, character: ASCII_MINUS, last_char: 1'b0};
        if (out_ready) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        out_req = '{valid: 1'b1,
                    character: ASCII_ZERO + {4'b0000, top_digit},
                    last_char: (left_q == LeftW'(1))};
        if (out_ready) begin
          bcd_d  = bcd_shl;
          left_d = left_q - LeftW'(1);
          if (left_q == LeftW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      neg_q   <= 1'b0;
      step_q  <= '0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
      step_q  <= step_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  sida_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (out_req),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### rtl/sida_dabble_step.sv
// ----------------------------------------------------------------------------
// sida_dabble_step - shared binary to BCD step unit
// Folds BITS_PER_STEP magnitude bits into the BCD digits (add 3, then shift).
// ----------------------------------------------------------------------------
module sida_dabble_step import sida_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic [4*(VALUE_WIDTH*3/10+1)-1:0] bcd_i,
  input  logic [BITS_PER_STEP-1:0]          bits_i,
  output logic [4*(VALUE_WIDTH*3/10+1)-1:0] bcd_o
);

  localparam int Digits = VALUE_WIDTH * 3 / 10 + 1;
  localparam int BcdW   = 4 * Digits;

  logic [BcdW-1:0] acc;
  logic [3:0]      col;

  always_comb begin
    acc = bcd_i;
    col = '0;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      // columns are independent: correct each before the shift
      for (int d = 0; d < Digits; d++) begin
        col = acc[4*d +: 4];
        if (col >= 4'd5) begin
          acc[4*d +: 4] = col + 4'd3;
        end
      end
      acc = {acc[BcdW-2:0], bits_i[BITS_PER_STEP-1-s]};
    end
    bcd_o = acc;
  end

endmodule

### rtl/sida_out_reg.sv
// ----------------------------------------------------------------------------
// sida_out_reg - output character register
// Holds one character request until the receiver takes it.
// ----------------------------------------------------------------------------
module sida_out_reg import sida_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  char_req_t req_i,
  output logic      ready_o,
  output logic      m_axis_tvalid,
  input  logic      m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] character
  output logic      m_axis_tlast     // last_char
);

  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       last_q;

  // free when empty or being emptied this cycle
  assign ready_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = req_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && req_i.valid) begin
      char_q <= req_i.character;
      last_q <= req_i.last_char;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = char_q;
  assign m_axis_tlast  = last_q;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for signed_int_to_decimal_ascii
// Sends signed integers over the input stream and checks each output
// character and its tlast against text worked out inside the bench.
// ----------------------------------------------------------------------------
module tb;
  import sida_pkg::*;

  localparam int VALUE_W      = VALUE_WIDTH_DEF;
  localparam int DATA_W       = ((VALUE_W + 7) / 8) * 8;
  localparam int DIGIT_SLOTS  = (VALUE_W * 3) / 10 + 1;
  localparam int N_DIRECTED   = 21;
  localparam int N_RANDOM     = 110;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  // one character of decimal text as it leaves the block
  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } text_char_t;

  // receiver behaviour over one stretch
  typedef enum int unsigned {
    RX_OPEN,    // always ready
    RX_PATCHY,  // ready about half the time
    RX_SPARSE   // ready about one cycle in four
  } rx_style_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;   // [31:0] value
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // [7:0] character
  logic              m_axis_tlast;        // last_char

  text_char_t  pending_text[$];   // characters still owed by the block
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          rx_hold_pending = 1'b0;

  logic [VALUE_W-1:0] directed_value [N_DIRECTED];
  string              directed_text  [N_DIRECTED];

  signed_int_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Decimal text of a signed value: the magnitude is taken unsigned, so the
  // most negative value needs no special handling, then divided down by ten.
  function automatic void predict_decimal_text(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] magnitude;
    logic [3:0]         digits [DIGIT_SLOTS];
    int unsigned        n_digits;
    logic               negative;
    negative  = value[VALUE_W-1];
    magnitude = negative ? (~value + 1'b1) : value;
    n_digits  = 0;
    do begin
      digits[n_digits] = 4'(magnitude % 10);
      n_digits++;
      magnitude = magnitude / 10;
    end while (magnitude != 0 && n_digits < DIGIT_SLOTS);
    if (negative) pending_text.push_back('{ASCII_MINUS, 1'b0});
    for (int i = n_digits; i > 0; i--) begin
      pending_text.push_back('{ASCII_ZERO + 8'(digits[i-1]), 1'(i == 1)});
    end
  endfunction

  // typed-in text: tlast on its final character
  function automatic void queue_literal_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      pending_text.push_back('{8'(text[i]), 1'(i == text.len() - 1)});
    end
  endfunction

  // Mix of full-range words, tiny numbers, powers of ten +/- 1 and numbers
  // of random digit length, each negated half the time.
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    int unsigned        decade;
    int unsigned        k;
    decade = 1;
    k = $urandom_range(1, 9);
    for (int i = 0; i < k; i++) decade *= 10;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 19);
      2: v = decade + $urandom_range(0, 2) - 1;
      default: v = $urandom_range(0, decade - 1);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Holds the request up until accepted; the text is owed from that edge on.
  // An empty string means the text comes from the predictor.
  task automatic offer_value(input logic [VALUE_W-1:0] value, input string text);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'(value);
    do @(posedge clk_i); while (!s_axis_tready);
    if (text.len() == 0) predict_decimal_text(value);
    else queue_literal_text(text);
  endtask

  // bursts of back-to-back requests with random gaps between them
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // sender goes quiet until every owed character has come out
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_text.size() != 0);
  endtask

  // Receiver: stretches of its own style, plus one long hold-off on demand
  // so the block backs up and drops s_axis_tready.
  initial begin : rx_stall_pattern
    int unsigned stretch;
    rx_style_e   style;
    forever begin
      stretch = $urandom_range(10, 80);
      style   = rx_style_e'($urandom_range(0, 2));
      repeat (stretch) begin
        @(posedge clk_i);
        if (rx_hold_pending) begin
          rx_hold_pending = 1'b0;
          m_axis_tready <= 1'b0;
          repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        end
        case (style)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_PATCHY: m_axis_tready <= 1'($urandom_range(0, 1));
          default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // output side: every accepted character against the oldest owed one
  always @(posedge clk_i) begin : text_check
    text_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_text.size() == 0) begin
        note_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                m_axis_tdata, m_axis_tlast));
      end else begin
        want = pending_text.pop_front();
        if (m_axis_tdata !== want.character) begin
          note_mismatch($sformatf("character: expected 0x%02h, got 0x%02h",
                                  want.character, m_axis_tdata));
        end
        if (m_axis_tlast !== want.last_char) begin
          note_mismatch($sformatf("tlast on 0x%02h: expected %0b, got %0b",
                                  want.character, want.last_char, m_axis_tlast));
        end
      end
    end
  end

  initial begin : stimulus
    // directed rows: extremes, zero and +/-1 carry their text, the rest is predicted
    directed_value = '{
      32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      -32'sd100, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
      32'd999999999, 32'd1000000000, -32'sd1000000000, 32'h5555_5555,
      32'hAAAA_AAAA, 32'd1234567890, -32'sd1234567890, 32'd7, 32'd0
    };
    directed_text = '{
      "0", "1", "-1", "", "", "", "", "",
      "", "2147483647", "-2147483647", "-2147483648",
      "", "", "", "",
      "", "", "", "", "0"
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < N_DIRECTED; n++) begin
      offer_value(directed_value[n], directed_text[n]);
      pace_sender();
    end
    wait_for_drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      // long receiver hold-off while requests keep coming
      if (n == 40) rx_hold_pending = 1'b1;
      // and one full pause on the sending side
      if (n == 90) wait_for_drain();
      offer_value(random_value(), "");
      pace_sender();
    end
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_text.size() != 0) begin
      note_mismatch($sformatf("%0d characters never arrived", pending_text.size()));
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
